### rtl/core/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared constants, types and the sine-squared table function of the sponge
// layer damping block.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int SINE_TABLE_BITS_DEF = 8;

    localparam int COORD_W   = 32;
    localparam int WIDTH_W   = 31;
    localparam int GAIN_W    = 17;
    localparam int DENS_W    = 31;
    localparam int VEL_W     = 32;
    localparam int TEND_W    = 32;
    localparam int SCALE_W   = 17;
    localparam int FRAC_BITS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [SCALE_W-1:0] Q_ONE = SCALE_W'(1 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_EDGE       = 3'd0,
        REG_UPPER_EDGE       = 3'd1,
        REG_TOP_WIDTH        = 3'd2,
        REG_TOP_INV_WIDTH    = 3'd3,
        REG_TOP_GAIN         = 3'd4,
        REG_BOTTOM_WIDTH     = 3'd5,
        REG_BOTTOM_INV_WIDTH = 3'd6,
        REG_BOTTOM_GAIN      = 3'd7
    } cfg_reg_t;

    // per-stage advance strobes of the layer pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } sld_adv_t;

    // sin(pi/2 * x), x and result in Q30
    function automatic logic [63:0] quarter_sine_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        x2 = (x * x) >> 30;
        p  = 64'd172271;
        p  = 64'd5026995    - ((x2 * p) >> 30);
        p  = 64'd85569306   - ((x2 * p) >> 30);
        p  = 64'd693598670  - ((x2 * p) >> 30);
        p  = 64'd1686629713 - ((x2 * p) >> 30);
        return (x * p) >> 30;
    endfunction

    // table entry k: squared sine in unsigned Q1.16, clipped to one, running maximum
    function automatic logic [SCALE_W-1:0] sine_sq_entry(input int k, input int bits);
        logic [63:0] s;
        logic [63:0] sq;
        logic [63:0] best;
        best = 64'd0;
        for (int j = 0; j <= k; j++) begin
            s = quarter_sine_q30(64'(j) << (30 - bits));
            if (s > 64'd1073741824) begin
                s = 64'd1073741824;
            end
            sq = (s * s) >> 44;
            if (sq > 64'd65536) begin
                sq = 64'd65536;
            end
            if (sq > best) begin
                best = sq;
            end
        end
        return best[SCALE_W-1:0];
    endfunction

endpackage

### rtl/core/sld_layer.sv
// ----------------------------------------------------------------------------
// sld_layer
// Four-stage pipeline for one sponge layer: membership, fraction of the
// layer depth, table lookup and linear interpolation of sin^2.
// ----------------------------------------------------------------------------
module sld_layer
    import sld_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic                      clk,
    input  sld_adv_t                  adv,
    input  logic signed [COORD_W:0]   inward,
    input  logic [WIDTH_W-1:0]        width,
    input  logic [WIDTH_W-1:0]        inv_width,
    output logic [SCALE_W-1:0]        scale
);

    localparam int ENTRIES = (1 << SINE_TABLE_BITS) + 1;
    localparam int REM_W   = FRAC_BITS - SINE_TABLE_BITS;
    localparam int IDX_W   = SINE_TABLE_BITS + 1;
    localparam int PROD_W  = 2 * WIDTH_W;

    logic [SCALE_W-1:0] tbl [ENTRIES];

    for (genvar k = 0; k < ENTRIES; k++) begin : g_tbl
        assign tbl[k] = sine_sq_entry(k, SINE_TABLE_BITS);
    end

    // stage 1: membership
    logic                act_next;
    logic                full_next;
    logic [WIDTH_W-1:0]  u_next;
    logic                act1_reg;
    logic                full1_reg;
    logic [WIDTH_W-1:0]  u1_reg;

    assign act_next  = (width != '0) && (inward < $signed({2'b00, width}));
    // at or past the domain edge the fraction is one
    assign full_next = (inward <= 0);
    assign u_next    = width - inward[WIDTH_W-1:0];

    // stage 2: fraction product
    logic                act2_reg;
    logic                full2_reg;
    logic [PROD_W-1:0]   prod2_reg;

    // stage 3: table lookup
    logic [SCALE_W-1:0]  f3;
    logic [IDX_W-1:0]    idx3;
    logic [SCALE_W-1:0]  a_next;
    logic [SCALE_W-1:0]  diff_next;
    logic [SCALE_W-1:0]  a3_reg;
    logic [SCALE_W-1:0]  diff3_reg;
    logic [REM_W-1:0]    rem3_reg;

    always_comb
    begin
        if (full2_reg || (prod2_reg[PROD_W-1:FRAC_BITS] > (PROD_W-FRAC_BITS)'(Q_ONE))) begin
            f3 = Q_ONE;
        end
        else begin
            f3 = prod2_reg[FRAC_BITS+SCALE_W-1:FRAC_BITS];
        end
        idx3 = f3[SCALE_W-1:REM_W];
        if (!act2_reg) begin
            a_next    = '0;
            diff_next = '0;
        end
        else if (idx3[IDX_W-1]) begin
            a_next    = tbl[ENTRIES-1];
            diff_next = '0;
        end
        else begin
            a_next    = tbl[idx3];
            diff_next = tbl[IDX_W'(idx3 + 1'b1)] - tbl[idx3];
        end
    end

    // stage 4: interpolation
    logic [SCALE_W+REM_W-1:0] interp4;
    logic [SCALE_W-1:0]       scale4_reg;

    assign interp4 = diff3_reg * rem3_reg;

    always_ff @(posedge clk)
    begin
        if (adv.s1) begin
            act1_reg  <= act_next;
            full1_reg <= full_next;
            u1_reg    <= u_next;
        end
        if (adv.s2) begin
            act2_reg  <= act1_reg;
            full2_reg <= full1_reg;
            prod2_reg <= u1_reg * inv_width;
        end
        if (adv.s3) begin
            a3_reg    <= a_next;
            diff3_reg <= diff_next;
            rem3_reg  <= f3[REM_W-1:0];
        end
        if (adv.s4) begin
            scale4_reg <= a3_reg + interp4[SCALE_W+REM_W-1:REM_W];
        end
    end

    assign scale = scale4_reg;

endmodule

### rtl/core/sponge_layer_momentum_damping.sv
// ----------------------------------------------------------------------------
// sponge_layer_momentum_damping
// Rayleigh damping of momentum tendencies in top and bottom sponge layers,
// signed Q16.16, saturating.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    position, density, vel xyz, tend xyz
//  m_axis    out  m_axis_tvalid/tready    damped xyz; tuser = saturated
//  cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one cell per cycle sustained while m_axis accepts; the result passes
// through the eight register stages (membership and magnitude,
// fraction multiply, table, interpolation, gain, split damping multiply, sum,
// subtract and clip).
// every stage holds its own valid bit and advances when the next one is free,
// so bubbles collapse and a stall on m_axis holds data without loss.
// rst_n clears valid bits and loads the register reset values; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module sponge_layer_momentum_damping
    import sld_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // position[31:0] density[62:32] vel_x[94:63] vel_y[126:95] vel_z[158:127]
    // tend_x[190:159] tend_y[222:191] tend_z[254:223] zero[255]
    input  logic [255:0]          s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // damped_x[31:0] damped_y[63:32] damped_z[95:64]
    output logic [95:0]           m_axis_tdata,
    // saturated[0]
    output logic                  m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NCOMP = 3;
    localparam int MAG_W = VEL_W;
    localparam int M_W   = DENS_W + MAG_W - FRAC_BITS;
    localparam int COEF_W = SCALE_W + 1;
    localparam int PH_W  = (M_W - 32) + COEF_W;
    localparam int PL_W  = 32 + COEF_W;
    localparam int D_W   = PH_W + FRAC_BITS + 1;
    localparam int R_W   = D_W + 2;

    // configuration registers
    logic [COORD_W-1:0] lower_edge_reg;
    logic [COORD_W-1:0] upper_edge_reg;
    logic [WIDTH_W-1:0] top_width_reg;
    logic [WIDTH_W-1:0] top_inv_width_reg;
    logic [GAIN_W-1:0]  top_gain_reg;
    logic [WIDTH_W-1:0] bottom_width_reg;
    logic [WIDTH_W-1:0] bottom_inv_width_reg;
    logic [GAIN_W-1:0]  bottom_gain_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lower_edge_reg       <= '0;
            upper_edge_reg       <= COORD_W'(1 << FRAC_BITS);
            top_width_reg        <= '0;
            top_inv_width_reg    <= '0;
            top_gain_reg         <= '0;
            bottom_width_reg     <= '0;
            bottom_inv_width_reg <= '0;
            bottom_gain_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_LOWER_EDGE:       lower_edge_reg       <= cfg_data;
                REG_UPPER_EDGE:       upper_edge_reg       <= cfg_data;
                REG_TOP_WIDTH:        top_width_reg        <= cfg_data[WIDTH_W-1:0];
                REG_TOP_INV_WIDTH:    top_inv_width_reg    <= cfg_data[WIDTH_W-1:0];
                REG_TOP_GAIN:         top_gain_reg         <= cfg_data[GAIN_W-1:0];
                REG_BOTTOM_WIDTH:     bottom_width_reg     <= cfg_data[WIDTH_W-1:0];
                REG_BOTTOM_INV_WIDTH: bottom_inv_width_reg <= cfg_data[WIDTH_W-1:0];
                REG_BOTTOM_GAIN:      bottom_gain_reg      <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [COORD_W-1:0] position;
    logic [DENS_W-1:0]  density;
    logic [VEL_W-1:0]   vel_in  [NCOMP];
    logic [TEND_W-1:0]  tend_in [NCOMP];

    assign position   = s_axis_tdata[31:0];
    assign density    = s_axis_tdata[62:32];
    assign vel_in[0]  = s_axis_tdata[94:63];
    assign vel_in[1]  = s_axis_tdata[126:95];
    assign vel_in[2]  = s_axis_tdata[158:127];
    assign tend_in[0] = s_axis_tdata[190:159];
    assign tend_in[1] = s_axis_tdata[222:191];
    assign tend_in[2] = s_axis_tdata[254:223];

    // stage valids and advance strobes
    logic [8:1] vld_reg;
    logic [8:1] en;

    assign en[8] = !vld_reg[8] || m_axis_tready;
    for (genvar s = 1; s < 8; s++) begin : g_en
        assign en[s] = !vld_reg[s] || en[s+1];
    end

    assign s_axis_tready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            if (en[1]) begin
                vld_reg[1] <= s_axis_tvalid;
            end
            for (int s = 2; s <= 8; s++) begin
                if (en[s]) begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // layer coefficient pipelines, stages 1 to 4
    sld_adv_t             adv;
    logic signed [COORD_W:0] dist_top;
    logic signed [COORD_W:0] dist_bot;
    logic [SCALE_W-1:0]   scale_top;
    logic [SCALE_W-1:0]   scale_bot;

    assign adv.s1 = en[1];
    assign adv.s2 = en[2];
    assign adv.s3 = en[3];
    assign adv.s4 = en[4];

    assign dist_top = $signed({upper_edge_reg[COORD_W-1], upper_edge_reg})
                    - $signed({position[COORD_W-1], position});
    assign dist_bot = $signed({position[COORD_W-1], position})
                    - $signed({lower_edge_reg[COORD_W-1], lower_edge_reg});

    sld_layer #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_top (
        .clk       (clk),
        .adv       (adv),
        .inward    (dist_top),
        .width     (top_width_reg),
        .inv_width (top_inv_width_reg),
        .scale     (scale_top)
    );

    sld_layer #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_bot (
        .clk       (clk),
        .adv       (adv),
        .inward    (dist_bot),
        .width     (bottom_width_reg),
        .inv_width (bottom_inv_width_reg),
        .scale     (scale_bot)
    );

    // momentum path
    logic [DENS_W-1:0]        rho1_reg;
    logic [MAG_W-1:0]         mag1_reg  [NCOMP];
    logic [NCOMP-1:0]         neg_reg   [1:7];
    logic [TEND_W-1:0]        tend_reg  [1:7][NCOMP];
    logic [M_W-1:0]           m_reg     [2:5][NCOMP];
    logic [DENS_W+MAG_W-1:0]  rho_mag   [NCOMP];
    logic [2*SCALE_W-1:0]     gs_top;
    logic [2*SCALE_W-1:0]     gs_bot;
    logic [COEF_W-1:0]        coef5_reg;
    logic [PH_W-1:0]          ph6_reg   [NCOMP];
    logic [PL_W-1:0]          pl6_reg   [NCOMP];
    logic [D_W-1:0]           d7_reg    [NCOMP];
    logic signed [R_W-1:0]    r8        [NCOMP];
    logic [NCOMP-1:0]         clip8;
    logic [TEND_W-1:0]        damped_next [NCOMP];
    logic [TEND_W-1:0]        damped_reg  [NCOMP];
    logic                     sat_reg;

    assign gs_top = top_gain_reg * scale_top;
    assign gs_bot = bottom_gain_reg * scale_bot;

    always_comb
    begin
        for (int c = 0; c < NCOMP; c++) begin
            rho_mag[c] = rho1_reg * mag1_reg[c];
            // damping opposes the velocity
            if (neg_reg[7][c]) begin
                r8[c] = $signed(R_W'($signed(tend_reg[7][c]))) + $signed(R_W'(d7_reg[c]));
            end
            else begin
                r8[c] = $signed(R_W'($signed(tend_reg[7][c]))) - $signed(R_W'(d7_reg[c]));
            end
            clip8[c] = (r8[c][R_W-1:TEND_W-1] != {(R_W-TEND_W+1){r8[c][R_W-1]}});
            if (!clip8[c]) begin
                damped_next[c] = r8[c][TEND_W-1:0];
            end
            else if (r8[c][R_W-1]) begin
                damped_next[c] = {1'b1, {(TEND_W-1){1'b0}}};
            end
            else begin
                damped_next[c] = {1'b0, {(TEND_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1]) begin
            rho1_reg <= density;
            for (int c = 0; c < NCOMP; c++) begin
                neg_reg[1][c]  <= vel_in[c][VEL_W-1];
                mag1_reg[c]    <= vel_in[c][VEL_W-1] ? (~vel_in[c] + 1'b1) : vel_in[c];
                tend_reg[1][c] <= tend_in[c];
            end
        end
        if (en[2]) begin
            neg_reg[2] <= neg_reg[1];
            for (int c = 0; c < NCOMP; c++) begin
                m_reg[2][c]    <= rho_mag[c][DENS_W+MAG_W-1:FRAC_BITS];
                tend_reg[2][c] <= tend_reg[1][c];
            end
        end
        for (int s = 3; s <= 5; s++) begin
            if (en[s]) begin
                neg_reg[s] <= neg_reg[s-1];
                for (int c = 0; c < NCOMP; c++) begin
                    m_reg[s][c]    <= m_reg[s-1][c];
                    tend_reg[s][c] <= tend_reg[s-1][c];
                end
            end
        end
        if (en[5]) begin
            coef5_reg <= COEF_W'(gs_top[2*SCALE_W-1:FRAC_BITS])
                       + COEF_W'(gs_bot[2*SCALE_W-1:FRAC_BITS]);
        end
        // damping product split at bit 32 of m
        if (en[6]) begin
            neg_reg[6] <= neg_reg[5];
            for (int c = 0; c < NCOMP; c++) begin
                ph6_reg[c]     <= m_reg[5][c][M_W-1:32] * coef5_reg;
                pl6_reg[c]     <= m_reg[5][c][31:0] * coef5_reg;
                tend_reg[6][c] <= tend_reg[5][c];
            end
        end
        if (en[7]) begin
            neg_reg[7] <= neg_reg[6];
            for (int c = 0; c < NCOMP; c++) begin
                d7_reg[c]      <= D_W'({ph6_reg[c], {FRAC_BITS{1'b0}}})
                                + D_W'(pl6_reg[c][PL_W-1:FRAC_BITS]);
                tend_reg[7][c] <= tend_reg[6][c];
            end
        end
        if (en[8]) begin
            for (int c = 0; c < NCOMP; c++) begin
                damped_reg[c] <= damped_next[c];
            end
            sat_reg <= |clip8;
        end
    end

    assign m_axis_tvalid = vld_reg[8];
    assign m_axis_tdata  = {damped_reg[2], damped_reg[1], damped_reg[0]};
    assign m_axis_tuser  = sat_reg;

endmodule
